[design/stc_pkg.sv]
`default_nettype none
package stc_pkg;

	localparam int unsigned MAX_SEGMENTS = 16;
	localparam int unsigned IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int unsigned CNT_W        = 5;
	localparam int unsigned ADDR_W       = 20;
	localparam int unsigned END_W        = ADDR_W + 1;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);

	localparam logic [1:0] MODE_ALLOC  = 2'd0;
	localparam logic [1:0] MODE_ACCESS = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} stc_cmd_t;

	typedef struct packed {
		logic scan_end;
	} stc_status_t;

endpackage
`default_nettype wire

[design/segment_table_checker_unit.sv]
`default_nettype none
// Segment table checker.
// Request channel: drive mode, start_addr and region_len with start high;
// the transaction is taken at a rising edge where start is high and busy
// is low. Mode 0 allocates a segment, 1 checks an access, 2 clears the
// table, 3 is ignored and reports a fault.
// Result channel: done is high for one cycle with success, bytes_in_use
// and segments_in_use valid in that cycle. The receiver cannot stall, so
// the result must be sampled in that cycle.
// Timing: the walk over the segment table reads one entry per cycle from
// its single read port, over the N entries present before the transaction
// (N at most 16). busy is low again during the done cycle, so the next
// request may be taken at the edge that ends the done cycle.
// Configuration: mem_limit_we and mem_limit_wdata load the memory limit;
// write it only while busy is low and no result is pending.
// Reset: the table is empty, bytes in use zero, the limit all ones.
module segment_table_checker_unit (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire  [1:0]                  mode,
	input  wire  [stc_pkg::ADDR_W-1:0]  start_addr,
	input  wire  [stc_pkg::ADDR_W-1:0]  region_len,
	input  wire                         mem_limit_we,
	input  wire  [stc_pkg::ADDR_W-1:0]  mem_limit_wdata,
	output logic                        done,
	output logic                        success,
	output logic [stc_pkg::ADDR_W-1:0]  bytes_in_use,
	output logic [stc_pkg::CNT_W-1:0]   segments_in_use
);

	stc_pkg::stc_cmd_t    cmd;
	stc_pkg::stc_status_t status;

	stc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	stc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.mem_limit_we    (mem_limit_we),
		.mem_limit_wdata (mem_limit_wdata),
		.mode            (mode),
		.start_addr      (start_addr),
		.region_len      (region_len),
		.done            (done),
		.success         (success),
		.bytes_in_use    (bytes_in_use),
		.segments_in_use (segments_in_use)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a transaction is still in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		segments_in_use <= stc_pkg::MAX_CNT)
		else $error("segment count above table depth");

	a_fault_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !success) |-> ($stable(segments_in_use) && $stable(bytes_in_use)))
		else $error("faulted transaction changed the table state");

endmodule
`default_nettype wire

[design/stc_ctrl.sv]
`default_nettype none
module stc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	output stc_pkg::stc_cmd_t    cmd,
	input  stc_pkg::stc_status_t status
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				// last read data is folded into the flags at this edge
				if (status.scan_end) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

[design/stc_dp.sv]
`default_nettype none
module stc_dp (
	input  wire                              clk,
	input  wire                              arst_n,
	input  stc_pkg::stc_cmd_t                cmd,
	output stc_pkg::stc_status_t             status,
	input  wire                              mem_limit_we,
	input  wire  [stc_pkg::ADDR_W-1:0]       mem_limit_wdata,
	input  wire  [1:0]                       mode,
	input  wire  [stc_pkg::ADDR_W-1:0]       start_addr,
	input  wire  [stc_pkg::ADDR_W-1:0]       region_len,
	output logic                             done,
	output logic                             success,
	output logic [stc_pkg::ADDR_W-1:0]       bytes_in_use,
	output logic [stc_pkg::CNT_W-1:0]        segments_in_use
);

	logic [stc_pkg::ADDR_W-1:0] seg_start_mem [stc_pkg::MAX_SEGMENTS];
	logic [stc_pkg::END_W-1:0]  seg_end_mem   [stc_pkg::MAX_SEGMENTS];

	logic [stc_pkg::ADDR_W-1:0] limit_q;
	logic [stc_pkg::CNT_W-1:0]  count_q;
	logic [stc_pkg::ADDR_W-1:0] used_q;
	logic [1:0]                 mode_q;
	logic [stc_pkg::ADDR_W-1:0] first_q;
	logic [stc_pkg::ADDR_W-1:0] len_q;
	logic [stc_pkg::END_W-1:0]  last_q;
	logic                       over_last_q;
	logic                       over_total_q;
	logic                       full_q;
	logic                       clash_q;
	logic                       hit_q;
	logic [stc_pkg::CNT_W-1:0]  idx_q;
	logic                       rd_valid_s1;
	logic [stc_pkg::ADDR_W-1:0] seg_s_s1;
	logic [stc_pkg::END_W-1:0]  seg_e_s1;
	logic                       success_q;
	logic                       done_q;

	logic [stc_pkg::END_W-1:0]  last_d;
	logic [stc_pkg::END_W-1:0]  total_d;
	logic [stc_pkg::END_W-1:0]  first_ext;
	logic [stc_pkg::END_W-1:0]  seg_s_ext;
	logic                       rd_en;
	logic                       clash_hit;
	logic                       cover_hit;
	logic                       ok;

	assign last_d    = {1'b0, start_addr} + {1'b0, region_len};
	assign total_d   = {1'b0, used_q} + {1'b0, region_len};
	assign first_ext = {1'b0, first_q};
	assign seg_s_ext = {1'b0, seg_s_s1};

	assign status.scan_end = (idx_q == count_q);
	assign rd_en           = cmd.scan && !status.scan_end;

	assign clash_hit = ((last_q < seg_e_s1) && (last_q > seg_s_ext)) ||
	                   ((first_ext > seg_s_ext) && (first_ext < seg_e_s1));
	assign cover_hit = (first_ext >= seg_s_ext) && (last_q <= seg_e_s1);

	always_comb begin
		case (mode_q)
			stc_pkg::MODE_ALLOC:  ok = !over_last_q && !over_total_q && !full_q && !clash_q;
			stc_pkg::MODE_ACCESS: ok = !over_last_q && hit_q;
			stc_pkg::MODE_CLEAR:  ok = 1'b1;
			default:              ok = 1'b0;
		endcase
	end

	// table storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.finish && ok && (mode_q == stc_pkg::MODE_ALLOC)) begin
			seg_start_mem[count_q[stc_pkg::IDX_W-1:0]] <= first_q;
			seg_end_mem[count_q[stc_pkg::IDX_W-1:0]]   <= last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			seg_s_s1 <= seg_start_mem[idx_q[stc_pkg::IDX_W-1:0]];
			seg_e_s1 <= seg_end_mem[idx_q[stc_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			first_q <= start_addr;
			len_q   <= region_len;
			last_q  <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q      <= '1;
			count_q      <= '0;
			used_q       <= '0;
			over_last_q  <= 1'b0;
			over_total_q <= 1'b0;
			full_q       <= 1'b0;
			clash_q      <= 1'b0;
			hit_q        <= 1'b0;
			idx_q        <= '0;
			rd_valid_s1  <= 1'b0;
			success_q    <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q      <= cmd.finish;
			rd_valid_s1 <= rd_en;
			if (mem_limit_we) begin
				limit_q <= mem_limit_wdata;
			end
			if (cmd.load) begin
				over_last_q  <= last_d > {1'b0, limit_q};
				over_total_q <= total_d > {1'b0, limit_q};
				full_q       <= count_q >= stc_pkg::MAX_CNT;
				clash_q      <= 1'b0;
				hit_q        <= 1'b0;
				idx_q        <= '0;
			end
			if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
			// fold each returned entry into the verdict flags
			if (rd_valid_s1) begin
				if (clash_hit) begin
					clash_q <= 1'b1;
				end
				if (cover_hit) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				success_q <= ok;
				if (mode_q == stc_pkg::MODE_CLEAR) begin
					count_q <= '0;
					used_q  <= '0;
				end else if (ok && (mode_q == stc_pkg::MODE_ALLOC)) begin
					count_q <= count_q + 1'b1;
					used_q  <= used_q + len_q;
				end
			end
		end
	end

	assign done            = done_q;
	assign success         = success_q;
	assign bytes_in_use    = used_q;
	assign segments_in_use = count_q;

endmodule
`default_nettype wire

[verif/tb_segment_table_checker_unit.sv]
`timescale 1ns / 1ps
module tb_segment_table_checker_unit;
	import stc_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 24;
	localparam int NUM_DIRECTED  = 24;

	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] bytes;
		logic [CNT_W-1:0]  segs;
	} verdict_t;

	typedef struct {
		logic [1:0]        md;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] len;
		bit                typed;
		verdict_t          want;
	} request_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        mode = 2'd0;
	logic [ADDR_W-1:0] start_addr = '0;
	logic [ADDR_W-1:0] region_len = '0;
	logic              mem_limit_we = 1'b0;
	logic [ADDR_W-1:0] mem_limit_wdata = '0;
	wire               busy;
	wire               done;
	wire               success;
	wire  [ADDR_W-1:0] bytes_in_use;
	wire  [CNT_W-1:0]  segments_in_use;

	// shadow copy of the segment table and the limit
	logic [ADDR_W-1:0] limit_m;
	logic [ADDR_W-1:0] seg_lo_m [MAX_SEGMENTS];
	logic [END_W-1:0]  seg_hi_m [MAX_SEGMENTS];
	int unsigned       seg_cnt_m;
	logic [ADDR_W-1:0] bytes_m;

	verdict_t     verdict_q [$];
	int           errors = 0;
	int           cycles = 0;
	bit           gaps_on = 1'b1;
	bit           row_typed = 1'b0;
	verdict_t     row_want = '0;
	request_row_t directed [NUM_DIRECTED];

	segment_table_checker_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.mode            (mode),
		.start_addr      (start_addr),
		.region_len      (region_len),
		.mem_limit_we    (mem_limit_we),
		.mem_limit_wdata (mem_limit_wdata),
		.done            (done),
		.success         (success),
		.bytes_in_use    (bytes_in_use),
		.segments_in_use (segments_in_use)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic verdict_t apply_request(input logic [1:0] md,
		input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] len);
		logic [END_W-1:0] last;
		logic [END_W-1:0] total;
		logic             ok;
		int unsigned      k;
		verdict_t         r;
		last  = END_W'(addr) + END_W'(len);
		total = END_W'(bytes_m) + END_W'(len);
		ok    = 1'b0;
		case (md)
			MODE_ALLOC: begin
				ok = (last <= END_W'(limit_m)) && (total <= END_W'(limit_m))
					&& (seg_cnt_m < MAX_SEGMENTS);
				for (k = 0; k < seg_cnt_m; k++) begin
					// strictly inside an existing segment at either end
					if ((last < seg_hi_m[k] && last > END_W'(seg_lo_m[k]))
						|| (END_W'(addr) > END_W'(seg_lo_m[k]) && END_W'(addr) < seg_hi_m[k]))
						ok = 1'b0;
				end
				if (ok) begin
					seg_lo_m[seg_cnt_m] = addr;
					seg_hi_m[seg_cnt_m] = last;
					seg_cnt_m++;
					bytes_m = total[ADDR_W-1:0];
				end
			end
			MODE_ACCESS: begin
				if (last <= END_W'(limit_m)) begin
					for (k = 0; k < seg_cnt_m; k++) begin
						if (addr >= seg_lo_m[k] && last <= seg_hi_m[k])
							ok = 1'b1;
					end
				end
			end
			MODE_CLEAR: begin
				seg_cnt_m = 0;
				bytes_m   = '0;
				ok        = 1'b1;
			end
			default: ok = 1'b0;
		endcase
		r.ok    = ok;
		r.bytes = bytes_m;
		r.segs  = CNT_W'(seg_cnt_m);
		return r;
	endfunction

	always @(posedge clk) begin : result_monitor
		verdict_t got;
		verdict_t want;
		verdict_t pred;
		if (arst_n) begin
			if (done) begin
				got.ok    = success;
				got.bytes = bytes_in_use;
				got.segs  = segments_in_use;
				if (verdict_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: success=%0b bytes=%0h segs=%0d",
						$time, got.ok, got.bytes, got.segs);
				end else begin
					want = verdict_q.pop_front();
					if (got.ok !== want.ok) begin
						errors++;
						$display("%0t: success mismatch: expected %0b actual %0b",
							$time, want.ok, got.ok);
					end
					if (got.bytes !== want.bytes) begin
						errors++;
						$display("%0t: bytes_in_use mismatch: expected %0h actual %0h",
							$time, want.bytes, got.bytes);
					end
					if (got.segs !== want.segs) begin
						errors++;
						$display("%0t: segments_in_use mismatch: expected %0d actual %0d",
							$time, want.segs, got.segs);
					end
				end
			end
			// a result retired at this edge belongs to an older transaction
			if (start && !busy) begin
				pred = apply_request(mode, start_addr, region_len);
				verdict_q.push_back(row_typed ? row_want : pred);
			end
		end
	end

	// entered and left at a falling edge; start stays high for a following transaction
	task automatic send_request(input logic [1:0] md, input logic [ADDR_W-1:0] addr,
		input logic [ADDR_W-1:0] len, input bit typed, input verdict_t want);
		bit taken;
		while (gaps_on && $urandom_range(0, 99) < 9) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		mode       <= md;
		start_addr <= addr;
		region_len <= len;
		row_typed  = typed;
		row_want   = want;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		@(negedge clk);
	endtask

	task automatic load_limit(input logic [ADDR_W-1:0] value);
		start <= 1'b0;
		while (verdict_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		mem_limit_we    <= 1'b1;
		mem_limit_wdata <= value;
		limit_m = value;
		@(negedge clk);
		mem_limit_we <= 1'b0;
	endtask

	task automatic run_random(input int count);
		int          n;
		int          pick;
		int unsigned k;
		int unsigned a;
		int unsigned l;
		int unsigned span;
		logic [1:0]  md;
		verdict_t    none;
		none = '0;
		for (n = 0; n < count; n++) begin
			span = (limit_m >> 4) + 1;
			pick = $urandom_range(0, 99);
			a    = $urandom_range(0, limit_m);
			l    = $urandom_range(0, span);
			// clear only rarely until the table is full, so that it tends to fill up first
			if ((seg_cnt_m == MAX_SEGMENTS) ? (pick < 30) : (pick < 2)) begin
				md = MODE_CLEAR;
			end else if (pick < 6) begin
				md = MODE_UNUSED;
				a  = $urandom_range(0, 20'hFFFFF);
				l  = $urandom_range(0, 20'hFFFFF);
			end else if (pick < 16) begin
				md = 2'($urandom_range(0, 1));
				a  = $urandom_range(0, 20'hFFFFF);
				l  = $urandom_range(0, 20'hFFFFF);
			end else if (pick < 60) begin
				md = MODE_ALLOC;
				if (seg_cnt_m > 0 && $urandom_range(0, 1))
					a = 32'(seg_hi_m[$urandom_range(0, seg_cnt_m - 1)]);
			end else if (pick < 92) begin
				md = MODE_ACCESS;
				if (seg_cnt_m > 0) begin
					k = $urandom_range(0, seg_cnt_m - 1);
					a = $urandom_range(seg_lo_m[k], seg_hi_m[k]);
					l = $urandom_range(0, seg_hi_m[k] - a) + ($urandom_range(0, 7) == 0);
				end
			end else begin
				md = MODE_ALLOC;
				if (seg_cnt_m > 0) begin
					k = $urandom_range(0, seg_cnt_m - 1);
					a = $urandom_range(seg_lo_m[k], seg_hi_m[k]);
				end
			end
			send_request(md, a[ADDR_W-1:0], l[ADDR_W-1:0], 1'b0, none);
		end
	endtask

	initial begin : stimulus
		int i;
		limit_m   = '1;
		seg_cnt_m = 0;
		bytes_m   = '0;
		directed = '{
			'{MODE_ACCESS, 20'h00000, 20'h00000, 1'b1, '{1'b0, 20'h00000, 5'd0}},
			'{MODE_UNUSED, 20'hFFFFF, 20'hFFFFF, 1'b1, '{1'b0, 20'h00000, 5'd0}},
			'{MODE_ALLOC,  20'h00000, 20'h00100, 1'b1, '{1'b1, 20'h00100, 5'd1}},
			'{MODE_ALLOC,  20'h00080, 20'h00010, 1'b1, '{1'b0, 20'h00100, 5'd1}},
			'{MODE_ALLOC,  20'h00000, 20'h00080, 1'b1, '{1'b0, 20'h00100, 5'd1}},
			'{MODE_ALLOC,  20'h00100, 20'h00100, 1'b1, '{1'b1, 20'h00200, 5'd2}},
			'{MODE_ALLOC,  20'h000F0, 20'h00020, 1'b1, '{1'b0, 20'h00200, 5'd2}},
			'{MODE_ACCESS, 20'h00100, 20'h00100, 1'b1, '{1'b1, 20'h00200, 5'd2}},
			'{MODE_ACCESS, 20'h000FF, 20'h00002, 1'b1, '{1'b0, 20'h00200, 5'd2}},
			'{MODE_ACCESS, 20'h00050, 20'h00000, 1'b1, '{1'b1, 20'h00200, 5'd2}},
			'{MODE_ALLOC,  20'hFFFFF, 20'hFFFFF, 1'b1, '{1'b0, 20'h00200, 5'd2}},
			'{MODE_ALLOC,  20'hFFFFF, 20'h00000, 1'b1, '{1'b1, 20'h00200, 5'd3}},
			'{MODE_ACCESS, 20'hFFFFF, 20'h00000, 1'b1, '{1'b1, 20'h00200, 5'd3}},
			'{MODE_ALLOC,  20'h00300, 20'hFFFFF, 1'b1, '{1'b0, 20'h00200, 5'd3}},
			'{MODE_ALLOC,  20'h00000, 20'hFFE00, 1'b1, '{1'b0, 20'h00200, 5'd3}},
			'{MODE_ALLOC,  20'h00200, 20'hFFDFF, 1'b1, '{1'b1, 20'hFFFFF, 5'd4}},
			'{MODE_ACCESS, 20'h00300, 20'h00010, 1'b1, '{1'b1, 20'hFFFFF, 5'd4}},
			'{MODE_ALLOC,  20'h00400, 20'h00010, 1'b0, '0},
			'{MODE_CLEAR,  20'h12345, 20'h06789, 1'b1, '{1'b1, 20'h00000, 5'd0}},
			'{MODE_ACCESS, 20'h00000, 20'h00000, 1'b1, '{1'b0, 20'h00000, 5'd0}},
			'{MODE_ALLOC,  20'h01000, 20'h00010, 1'b0, '0},
			'{MODE_ACCESS, 20'h01004, 20'h00004, 1'b0, '0},
			'{MODE_UNUSED, 20'h00000, 20'h00000, 1'b0, '0},
			'{MODE_ACCESS, 20'h01000, 20'h00011, 1'b0, '0}
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < NUM_DIRECTED; i++)
			send_request(directed[i].md, directed[i].addr, directed[i].len,
				directed[i].typed, directed[i].want);

		load_limit(20'h00000);
		run_random(60);
		load_limit(20'hFFFFF);
		gaps_on = 1'b0;
		run_random(120);
		gaps_on = 1'b1;
		load_limit(ADDR_W'($urandom_range(256, 4095)));
		run_random(120);
		load_limit(ADDR_W'($urandom_range(0, 20'hFFFFF)));
		run_random(120);
		load_limit(20'hFFFFF);
		run_random(130);

		// drain outstanding transactions
		start <= 1'b0;
		while (verdict_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
design/stc_pkg.sv
design/stc_ctrl.sv
design/stc_dp.sv
design/segment_table_checker_unit.sv
verif/tb_segment_table_checker_unit.sv
